// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the date to Unix seconds unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define DTUS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked check that also holds during reset.
`define DTUS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/dtus_pkg.sv =====
// Types, constants and helper functions for the date to Unix seconds unit.
`default_nettype none

package dtus_pkg;

    localparam logic [7:0] CharDash  = 8'h2d;
    localparam logic [7:0] CharPlus  = 8'h2b;
    localparam logic [7:0] CharZero  = 8'h30;
    localparam logic [7:0] CharNine  = 8'h39;
    localparam logic [7:0] CharSpace = 8'h20;
    localparam logic [7:0] CharTab   = 8'h09;
    localparam logic [7:0] CharCr    = 8'h0d;

    localparam logic [13:0] MinYear   = 14'd1900;
    localparam logic [6:0]  MaxMonth  = 7'd12;
    localparam logic [6:0]  MaxDay    = 7'd31;
    localparam logic [11:0] Recip25   = 12'd2622;   // ceil(2^16 / 25)
    localparam logic [23:0] EpochDays = 24'd719468;
    localparam logic [23:0] DaysPerYear = 24'd365;
    localparam logic signed [17:0] SecPerDay = 18'sd86400;
    localparam logic signed [38:0] MinSeconds = -39'sd2208988800;

    typedef struct packed {
        logic        ok;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } parse_t;

    typedef struct packed {
        logic        ok;
        logic [13:0] y;
        logic [11:0] q4;
        logic [6:0]  q100;
        logic [4:0]  q400;
        logic [8:0]  doy;
    } civil_t;

    typedef struct packed {
        logic               ok;
        logic signed [22:0] days;
    } days_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CharZero) && (c <= CharNine);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return ((c >= CharTab) && (c <= CharCr)) || (c == CharSpace);
    endfunction

    // Two-character atoi; a negative or empty number gives 0.
    function automatic logic [6:0] atoi2(input logic [7:0] c0, input logic [7:0] c1);
        logic [6:0] d0;
        logic [6:0] d1;
        logic [6:0] v;
        d0 = {3'b000, c0[3:0]};
        d1 = {3'b000, c1[3:0]};
        v  = 7'd0;
        if (is_digit(c0)) begin
            v = is_digit(c1) ? (d0 * 7'd10 + d1) : d0;
        end else if (is_blank(c0) || (c0 == CharPlus)) begin
            v = is_digit(c1) ? d1 : 7'd0;
        end
        return v;
    endfunction

    // Days before the first of each month in a March-based year.
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] r;
        case (mp)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/dtus_parse.sv =====
// Stage 1: character checks, field parsing and range checks.
`default_nettype none

module dtus_parse import dtus_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        long_enough,
    input  wire logic [79:0] chars,
    output logic             out_valid,
    input  wire logic        out_ready,
    output parse_t           out_data
);

    logic       valid_reg;
    parse_t     data_reg;
    parse_t     data_next;
    logic [7:0] c [10];
    logic       year_digits;
    logic [13:0] year;
    logic [6:0] month;
    logic [6:0] day;

    always_comb begin
        for (int i = 0; i < 10; i++) begin
            c[i] = chars[8*i +: 8];
        end
        year_digits = is_digit(c[0]) && is_digit(c[1]) && is_digit(c[2]) && is_digit(c[3]);
        year = 14'(c[0][3:0]) * 14'd1000 + 14'(c[1][3:0]) * 14'd100
             + 14'(c[2][3:0]) * 14'd10 + 14'(c[3][3:0]);
        month = atoi2(c[5], c[6]);
        day   = atoi2(c[8], c[9]);
        data_next.ok = long_enough && (c[4] == CharDash) && (c[7] == CharDash)
                     && year_digits && (year >= MinYear)
                     && (month != 7'd0) && (month <= MaxMonth)
                     && (day != 7'd0) && (day <= MaxDay);
        data_next.year  = year;
        data_next.month = month[3:0];
        data_next.day   = day[4:0];
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ===== rtl/dtus_civil.sv =====
// Stage 2: March-based year, day of year and leap-year quotients.
`default_nettype none

module dtus_civil import dtus_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  parse_t    in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output civil_t    out_data
);

    logic        valid_reg;
    civil_t      data_reg;
    civil_t      data_next;
    logic [13:0] y;
    logic [3:0]  mp;
    logic [23:0] p100;
    logic [21:0] p400;

    always_comb begin
        y  = in_data.year - ((in_data.month <= 4'd2) ? 14'd1 : 14'd0);
        mp = (in_data.month > 4'd2) ? (in_data.month - 4'd3) : (in_data.month + 4'd9);
        // divide by 25 through a reciprocal, exact for values below 2500
        p100 = 24'(y[13:2]) * 24'(Recip25);
        p400 = 22'(y[13:4]) * 22'(Recip25);
        data_next.ok   = in_data.ok;
        data_next.y    = y;
        data_next.q4   = y[13:2];
        data_next.q100 = p100[22:16];
        data_next.q400 = p400[20:16];
        data_next.doy  = month_start(mp) + 9'(in_data.day) - 9'd1;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ===== rtl/dtus_days.sv =====
// Stage 3: day count relative to 1970-01-01.
`default_nettype none

module dtus_days import dtus_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  civil_t    in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output days_t     out_data
);

    logic        valid_reg;
    days_t       data_reg;
    days_t       data_next;
    logic [23:0] sum;

    always_comb begin
        sum = 24'(in_data.y) * DaysPerYear + 24'(in_data.q4) - 24'(in_data.q100)
            + 24'(in_data.q400) + 24'(in_data.doy) - EpochDays;
        data_next.ok   = in_data.ok;
        data_next.days = signed'(sum[22:0]);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ===== rtl/dtus_scale.sv =====
// Stage 4: days to seconds, invalid results forced to zero; output register.
`default_nettype none

module dtus_scale import dtus_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  days_t            in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             out_ok,
    output logic [38:0]      out_seconds
);

    logic               valid_reg;
    logic               ok_reg;
    logic [38:0]        seconds_reg;
    logic signed [40:0] prod;
    logic [38:0]        seconds_next;

    always_comb begin
        prod = in_data.days * SecPerDay;
        seconds_next = in_data.ok ? prod[38:0] : 39'd0;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_valid && in_ready) begin
            ok_reg      <= in_data.ok;
            seconds_reg <= seconds_next;
        end
    end

    assign out_valid   = valid_reg;
    assign out_ok      = ok_reg;
    assign out_seconds = seconds_reg;

endmodule

`default_nettype wire

// ===== rtl/date_text_to_unix_seconds_unit.sv =====
// Top level: YYYY-MM-DD date text to Unix seconds at midnight.
//
//  Channel  Direction  Sideband (tuser)     Payload (tdata)
//  s_       in         long_enough          year_ch0..3, sep_one, month_ch0..1, sep_two, day_ch0..1
//  m_       out        valid_res            unix_seconds (39-bit signed, zero-padded to 40)
//
// Four register stages (parse, civil, days, scale).
// One transaction per cycle sustained while m_tready holds high; each stage has its own valid bit.
// A stage takes new data when it is empty or its successor moves, so bubbles
// collapse and a stalled output loses and repeats nothing.
// Synchronous active-low reset clears the valid bits only.
`default_nettype none
`include "assert_macros.svh"

module date_text_to_unix_seconds_unit import dtus_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,   // year_ch0..3, sep_one, month_ch0..1, sep_two, day_ch0..1
    input  wire logic [0:0]  s_tuser,   // long_enough
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // unix_seconds[38:0], zero pad
    output logic [0:0]       m_tuser    // valid_res
);

    logic        p_valid;
    logic        p_ready;
    parse_t      p_data;
    logic        c_valid;
    logic        c_ready;
    civil_t      c_data;
    logic        d_valid;
    logic        d_ready;
    days_t       d_data;
    logic        res_ok;
    logic [38:0] res_seconds;

    dtus_parse u_parse (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .long_enough (s_tuser[0]),
        .chars       (s_tdata),
        .out_valid   (p_valid),
        .out_ready   (p_ready),
        .out_data    (p_data)
    );

    dtus_civil u_civil (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (p_valid),
        .in_ready  (p_ready),
        .in_data   (p_data),
        .out_valid (c_valid),
        .out_ready (c_ready),
        .out_data  (c_data)
    );

    dtus_days u_days (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (c_valid),
        .in_ready  (c_ready),
        .in_data   (c_data),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .out_data  (d_data)
    );

    dtus_scale u_scale (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (d_valid),
        .in_ready    (d_ready),
        .in_data     (d_data),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_ok      (res_ok),
        .out_seconds (res_seconds)
    );

    assign m_tdata = {1'b0, res_seconds};
    assign m_tuser = res_ok;

    `DTUS_ASSERT(a_invalid_zero, (m_tvalid && !m_tuser[0]) |-> (m_tdata == 40'd0), "invalid result with nonzero seconds")
    `DTUS_ASSERT(a_valid_range, (m_tvalid && m_tuser[0]) |-> ($signed(m_tdata[38:0]) >= MinSeconds), "seconds below 1900-01-01")
    `DTUS_ASSERT(a_empty_out_ready, !m_tvalid |-> s_tready, "input stalled with empty output stage")
    `DTUS_ASSERT(a_pad_zero, m_tvalid |-> (m_tdata[39] == 1'b0), "tdata pad bit set")

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Testbench for the date text to Unix seconds unit: directed and random date texts.
`default_nettype none

module tb_top;
    import dtus_pkg::*;

    localparam int StallLimit = 1000;
    localparam int TailCycles = 16;

    typedef struct {
        bit         long_enough;
        logic [7:0] text [10];
    } date_text_t;

    typedef struct {
        bit          valid;
        logic [38:0] seconds;
    } unix_time_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;     // year_ch0..3, sep_one, month_ch0..1, sep_two, day_ch0..1
    logic [0:0]  s_tuser = '0;     // long_enough
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;          // unix_seconds[38:0], zero pad
    logic [0:0]  m_tuser;          // valid_res

    unix_time_t  due_unix_times [$];
    int          mismatches = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    date_text_to_unix_seconds_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // atoi over count bytes starting at position first
    function automatic longint atoi_field(input date_text_t d, input int first, input int count);
        int     i;
        bit     neg;
        longint v;
        i = 0;
        neg = 1'b0;
        v = 0;
        while (i < count && ((d.text[first+i] >= CharTab && d.text[first+i] <= CharCr)
                             || d.text[first+i] == CharSpace)) begin
            i++;
        end
        if (i < count && (d.text[first+i] == CharPlus || d.text[first+i] == CharDash)) begin
            neg = (d.text[first+i] == CharDash);
            i++;
        end
        while (i < count && d.text[first+i] >= CharZero && d.text[first+i] <= CharNine) begin
            v = v * 10 + longint'(d.text[first+i] - CharZero);
            i++;
        end
        return neg ? -v : v;
    endfunction

    function automatic unix_time_t civil_date_to_unix(input date_text_t d);
        unix_time_t r;
        longint     year, month, day, y, era, yoe, mp, doy, doe, days;
        r.valid = 1'b0;
        r.seconds = '0;
        year = atoi_field(d, 0, 4);
        month = atoi_field(d, 5, 2);
        day = atoi_field(d, 8, 2);
        if (d.long_enough && d.text[4] == CharDash && d.text[7] == CharDash
            && year >= 1900 && month >= 1 && month <= 12 && day >= 1 && day <= 31) begin
            y = year - ((month <= 2) ? 1 : 0);
            era = y / 400;
            yoe = y - era * 400;
            mp = (month > 2) ? month - 3 : month + 9;
            doy = (153 * mp + 2) / 5 + day - 1;
            doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
            days = era * 146097 + doe - 719468;
            r.valid = 1'b1;
            r.seconds = 39'(days * 86400);
        end
        return r;
    endfunction

    function automatic date_text_t text_of(input bit long_enough, input string s);
        date_text_t d;
        d.long_enough = long_enough;
        for (int i = 0; i < 10; i++) begin
            d.text[i] = s[i];
        end
        return d;
    endfunction

    function automatic date_text_t put_number(input date_text_t d, input int first,
                                              input int count, input int value);
        int v;
        v = value;
        for (int k = count - 1; k >= 0; k--) begin
            d.text[first+k] = 8'(CharZero + v % 10);
            v = v / 10;
        end
        return d;
    endfunction

    function automatic logic [7:0] random_blank();
        return ($urandom_range(5) == 5) ? CharSpace : 8'($urandom_range(13, 9));
    endfunction

    // mostly well-formed dates, then corrupted ones, then raw noise
    function automatic date_text_t random_date_text();
        date_text_t d;
        int         kind, year, month, day, pos;
        kind = $urandom_range(99);
        year = ($urandom_range(9) == 0) ? $urandom_range(1899, 1000) : $urandom_range(9999, 1900);
        month = ($urandom_range(9) == 0) ? (($urandom_range(1) == 0) ? 0 : $urandom_range(99, 13))
                                         : $urandom_range(12, 1);
        day = ($urandom_range(9) == 0) ? (($urandom_range(1) == 0) ? 0 : $urandom_range(99, 32))
                                       : $urandom_range(31, 1);
        d.long_enough = ($urandom_range(49) != 0);
        d.text[4] = CharDash;
        d.text[7] = CharDash;
        d = put_number(d, 0, 4, year);
        d = put_number(d, 5, 2, month);
        d = put_number(d, 8, 2, day);
        for (pos = 5; pos <= 8; pos += 3) begin
            if (d.text[pos] == CharZero && $urandom_range(3) == 0) begin
                case ($urandom_range(3))
                    0: d.text[pos] = random_blank();
                    1: d.text[pos] = CharPlus;
                    2: d.text[pos] = CharDash;
                    default: begin
                        d.text[pos] = d.text[pos+1];
                        d.text[pos+1] = 8'($urandom_range(255));
                    end
                endcase
            end
        end
        if (kind >= 70 && kind < 85) begin
            if ($urandom_range(3) == 0) begin
                d.long_enough = ~d.long_enough;
            end else begin
                pos = $urandom_range(9);
                d.text[pos] = 8'($urandom_range(255));
            end
        end else if (kind >= 85) begin
            d.long_enough = 1'($urandom_range(1));
            for (int i = 0; i < 10; i++) begin
                d.text[i] = 8'($urandom_range(255));
            end
            if ($urandom_range(1) == 0) begin
                d.text[4] = CharDash;
                d.text[7] = CharDash;
            end
        end
        return d;
    endfunction

    task automatic send_date(input date_text_t d);
        logic [79:0] packed_text;
        for (int i = 0; i < 10; i++) begin
            packed_text[8*i +: 8] = d.text[i];
        end
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= packed_text;
        s_tuser <= d.long_enough;
        do @(posedge aclk); while (!s_tready);
        due_unix_times.insert(due_unix_times.size(), civil_date_to_unix(d));
    endtask

    task automatic wait_until_drained();
        s_tvalid <= 1'b0;
        while (due_unix_times.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed();
        date_text_t d;
        send_idle_pct = 10;
        recv_idle_pct = 30;
        send_date(text_of(1, "1970-01-01"));
        send_date(text_of(1, "1969-12-31"));
        send_date(text_of(1, "1900-01-01"));
        send_date(text_of(1, "9999-12-31"));
        send_date(text_of(1, "1899-12-31"));
        send_date(text_of(1, "2000-02-29"));
        send_date(text_of(1, "2100-02-29"));
        send_date(text_of(1, "2023-02-31"));
        send_date(text_of(1, "2024-02-31"));
        send_date(text_of(0, "2024-05-17"));
        send_date(text_of(1, "2024/05-17"));
        send_date(text_of(1, "2024-05_17"));
        send_date(text_of(1, "2024-00-10"));
        send_date(text_of(1, "2024-13-10"));
        send_date(text_of(1, "2024-05-00"));
        send_date(text_of(1, "2024-05-32"));
        send_date(text_of(1, "2024- 5-\t7"));
        send_date(text_of(1, "2024-+5-+7"));
        send_date(text_of(1, "2024--5-07"));
        send_date(text_of(1, "-202-05-07"));
        send_date(text_of(1, "\n202-05-07"));
        send_date(text_of(1, "2024-5x-7y"));
        d = text_of(1, "2024-05-1x");
        d.text[9] = 8'h00;
        d.text[5] = 8'h0b;
        send_date(d);
        send_date(text_of(1, "19a9-05-05"));
        send_date(text_of(1, "    -  -  "));
        wait_until_drained();
    endtask

    task automatic test_random_stream(input int count, input int send_idle, input int recv_idle);
        send_idle_pct = send_idle;
        recv_idle_pct = recv_idle;
        for (int n = 0; n < count; n++) begin
            send_date(random_date_text());
        end
        wait_until_drained();
    endtask

    // sender holds off mid-stream until every outstanding result is back
    task automatic test_drain_holdoff();
        send_idle_pct = 0;
        recv_idle_pct = 50;
        for (int n = 0; n < 40; n++) begin
            send_date(random_date_text());
        end
        wait_until_drained();
        for (int n = 0; n < 40; n++) begin
            send_date(random_date_text());
        end
        wait_until_drained();
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        unix_time_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (due_unix_times.size() == 0) begin
                $error("result with none due: valid_res=%0b unix_seconds=%0d",
                       m_tuser[0], $signed(m_tdata[38:0]));
                mismatches++;
            end else begin
                want = due_unix_times.pop_front();
                if (m_tuser[0] !== want.valid) begin
                    $error("valid_res: expected %0b, actual %0b", want.valid, m_tuser[0]);
                    mismatches++;
                end
                if (m_tdata[38:0] !== want.seconds) begin
                    $error("unix_seconds: expected %0d, actual %0d",
                           $signed(want.seconds), $signed(m_tdata[38:0]));
                    mismatches++;
                end
            end
        end
    end

    initial begin : watchdog
        int stalled;
        stalled = 0;
        wait (aresetn === 1'b1);
        while (stalled < StallLimit) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stalled = 0;
            end else begin
                stalled++;
            end
        end
        $display("tb_top failed");
        $finish;
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random_stream(600, 19, 76);
        test_random_stream(600, 76, 19);
        test_drain_holdoff();
        test_random_stream(540, 0, 0);
        wait_until_drained();
        repeat (TailCycles) @(posedge aclk);
        if (mismatches == 0 && due_unix_times.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
